// ===== src/nmea_gga_field_extractor_macros.svh =====
// Assertion macros shared by the extractor RTL.
`ifndef NMEA_GGA_FIELD_EXTRACTOR_MACROS_SVH
`define NMEA_GGA_FIELD_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NGGA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ngga assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define NGGA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ngga assertion failed: next-cycle implication");

`endif

// ===== src/ngga_pkg.sv =====
// Shared types and constants of the GGA field extractor.
`default_nettype none

package ngga_pkg;

  // Field store geometry: ten kept fields, two 64-bit words each
  localparam int STORED     = 10;
  localparam int TEXT_WORDS = 2 * STORED;
  localparam int TEXT_AW    = $clog2(TEXT_WORDS);
  localparam int SLOT_W     = $clog2(STORED);
  localparam int LEN_W      = 5;
  localparam int KIND_W     = 4;
  localparam int WORD_W     = 64;

  // Characters with special meaning
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_A     = 8'h41;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NOT_GGA = 4'd0;
  localparam logic [KIND_W-1:0] KIND_NAME    = 4'd1;
  localparam logic [KIND_W-1:0] KIND_TIME    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_LAT     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_NS      = 4'd4;
  localparam logic [KIND_W-1:0] KIND_LON     = 4'd5;
  localparam logic [KIND_W-1:0] KIND_EW      = 4'd6;
  localparam logic [KIND_W-1:0] KIND_QUALITY = 4'd7;
  localparam logic [KIND_W-1:0] KIND_SATS    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_ALT     = 4'd9;
  localparam logic [KIND_W-1:0] KIND_UNIT    = 4'd10;

  // Saturation limit of the closed field counter
  localparam logic [3:0] FIELD_COUNT_MAX = 4'd15;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD0,
    ST_RD1,
    ST_EMIT
  } state_t;

  // Operation pending in the write-back cycle
  typedef enum logic {
    OP_CHAR,
    OP_CHECK
  } op_t;

  // Raw stored field handed to the output stage
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [LEN_W-1:0]  len;
    logic              last;
  } raw_t;

endpackage

`default_nettype wire

// ===== src/ngga_if.sv =====
// Byte input and result output channel interfaces.
`default_nettype none

interface ngga_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ngga_result_if;
  logic                              valid;
  logic                              ready;
  logic [ngga_pkg::KIND_W-1:0]       kind;
  logic [ngga_pkg::WORD_W-1:0]       text_low;
  logic [ngga_pkg::WORD_W-1:0]       text_high;
  logic [ngga_pkg::LEN_W-1:0]        text_length;
  logic                              truncated;
  logic                              last;

  modport source (output valid, output kind, output text_low, output text_high,
                  output text_length, output truncated, output last, input ready);
  modport sink (input valid, input kind, input text_low, input text_high,
                input text_length, input truncated, input last, output ready);
endinterface

`default_nettype wire

// ===== src/ngga_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ngga_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 20,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; rdata holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ngga_out_stage.sv =====
// Result formatter and output register: trims stored fields to their carried length.
`default_nettype none

module ngga_out_stage #(
  parameter int FIELD_CHARS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire ngga_pkg::raw_t raw,
  output logic                free,
  ngga_result_if.source       result
);

  logic                              single;
  logic [ngga_pkg::LEN_W-1:0]        carried;
  logic                              trunc;
  logic [ngga_pkg::WORD_W-1:0]       low_masked;
  logic [ngga_pkg::WORD_W-1:0]       high_masked;

  logic                              valid;
  logic [ngga_pkg::KIND_W-1:0]       kind;
  logic [ngga_pkg::WORD_W-1:0]       text_low;
  logic [ngga_pkg::WORD_W-1:0]       text_high;
  logic [ngga_pkg::LEN_W-1:0]        text_length;
  logic                              truncated;
  logic                              last;

  // Carried length and truncation flag
  always_comb begin
    single = raw.kind inside {ngga_pkg::KIND_NS, ngga_pkg::KIND_EW,
                              ngga_pkg::KIND_QUALITY, ngga_pkg::KIND_SATS,
                              ngga_pkg::KIND_UNIT};
    if (single) begin
      carried = (raw.len > 5'd0) ? 5'd1 : 5'd0;
      trunc   = (raw.len > 5'd1);
    end else begin
      carried = (raw.len > 5'(FIELD_CHARS)) ? 5'(FIELD_CHARS) : raw.len;
      trunc   = (raw.len > 5'(FIELD_CHARS));
    end
  end

  // Zero the bytes past the carried length
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      low_masked[8*i +: 8]  = (5'(i) < carried) ? raw.word0[8*i +: 8] : 8'h00;
      high_masked[8*i +: 8] = (5'(i + 8) < carried) ? raw.word1[8*i +: 8] : 8'h00;
    end
  end

  // Output register: valid is control, payload loads only
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind        <= raw.kind;
      text_low    <= low_masked;
      text_high   <= high_masked;
      text_length <= carried;
      truncated   <= trunc;
      last        <= raw.last;
    end
  end

  assign free               = !valid || result.ready;
  assign result.valid       = valid;
  assign result.kind        = kind;
  assign result.text_low    = text_low;
  assign result.text_high   = text_high;
  assign result.text_length = text_length;
  assign result.truncated   = truncated;
  assign result.last        = last;

endmodule

`default_nettype wire

// ===== src/nmea_gga_field_extractor.sv =====
// Top level: NMEA line splitter with memory-held GGA field store and result drain.
//
//   channel | dir | payload                                          | handshake
//   rx      | in  | rx_byte                                          | valid/ready
//   result  | out | kind text_low text_high text_length truncated last | valid/ready
//
// A stored character takes a text memory read, then a merge and write back; a
// comma closing the first field takes a read of the name word, then its check.
// Other bytes stay in the idle state. A newline on a GGA line drains up to ten
// fields, each through RD0, RD1 and EMIT, as the text memory has a single read
// port (two words per field); a not-GGA line goes straight to EMIT for its mark.
// rst is synchronous and clears control state only; the field memories need no
// clearing. A stalled result holds the drain; no byte is taken until it finishes.
`default_nettype none

`include "nmea_gga_field_extractor_macros.svh"

module nmea_gga_field_extractor #(
  parameter int LINE_BYTES  = 150,
  parameter int FIELD_CHARS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  ngga_byte_if.sink     rx,
  ngga_result_if.source result
);

  localparam int TAW = ngga_pkg::TEXT_AW;
  localparam int SW  = ngga_pkg::SLOT_W;
  localparam int LW  = ngga_pkg::LEN_W;
  localparam int WW  = ngga_pkg::WORD_W;

  // Line state
  logic [7:0]                  line_length, line_length_next;
  logic [3:0]                  closed_count, closed_count_next;
  logic [LW-1:0]               chars_in_field, chars_in_field_next;
  logic                        content_ended, content_ended_next;
  logic                        gga_match, gga_match_next;

  // Sequencer state
  ngga_pkg::state_t            state, state_next;
  ngga_pkg::op_t               op, op_next;
  logic [7:0]                  pend_byte, pend_byte_next;
  logic [2:0]                  pend_lane, pend_lane_next;
  logic [TAW-1:0]              pend_addr, pend_addr_next;
  logic                        pend_long, pend_long_next;
  logic [ngga_pkg::KIND_W-1:0] kind_cnt, kind_cnt_next;
  logic [WW-1:0]               word0, word0_next;
  logic [LW-1:0]               len_reg, len_reg_next;

  // Memory ports
  logic                        text_we, text_re;
  logic [TAW-1:0]              text_waddr, text_raddr;
  logic [WW-1:0]               text_wdata, text_rdata;
  logic                        len_we, len_re;
  logic [SW-1:0]               len_waddr, len_raddr;
  logic [LW-1:0]               len_wdata, len_rdata;

  // Misc
  logic                        rx_fire;
  logic                        slot_ok;
  logic [SW-1:0]               slot;
  logic [SW-1:0]               drain_slot;
  logic [3:0]                  next_field;
  logic                        emit_last;
  logic                        emit_load;
  logic                        out_free;
  ngga_pkg::raw_t              raw;

  // Storage slot of the open field; the HDOP field and fields past the eleventh are not kept
  always_comb begin
    slot_ok = 1'b0;
    slot    = '0;
    if (closed_count < 4'd8) begin
      slot_ok = 1'b1;
      slot    = SW'(closed_count);
    end else if (closed_count == 4'd9 || closed_count == 4'd10) begin
      slot_ok = 1'b1;
      slot    = SW'(closed_count - 4'd1);
    end
  end

  // Drain helpers: slot of the current kind and field index of the next kind
  assign drain_slot = SW'(kind_cnt - 4'd1);
  assign next_field = (kind_cnt < 4'd8) ? kind_cnt : kind_cnt + 4'd1;
  assign emit_last  = (kind_cnt == ngga_pkg::KIND_NOT_GGA) ||
                      (kind_cnt == ngga_pkg::KIND_UNIT) ||
                      (next_field >= closed_count);

  assign rx.ready = (state == ngga_pkg::ST_IDLE);
  assign rx_fire  = rx.valid && rx.ready;

  assign raw.kind  = kind_cnt;
  assign raw.word0 = word0;
  assign raw.word1 = text_rdata;
  assign raw.len   = len_reg;
  assign raw.last  = emit_last;

  // Next state, memory controls and line bookkeeping
  always_comb begin
    line_length_next    = line_length;
    closed_count_next   = closed_count;
    chars_in_field_next = chars_in_field;
    content_ended_next  = content_ended;
    gga_match_next      = gga_match;
    state_next          = state;
    op_next             = op;
    pend_byte_next      = pend_byte;
    pend_lane_next      = pend_lane;
    pend_addr_next      = pend_addr;
    pend_long_next      = pend_long;
    kind_cnt_next       = kind_cnt;
    word0_next          = word0;
    len_reg_next        = len_reg;
    text_we             = 1'b0;
    text_waddr          = pend_addr;
    text_wdata          = text_rdata;
    text_re             = 1'b0;
    text_raddr          = '0;
    len_we              = 1'b0;
    len_waddr           = slot;
    len_wdata           = chars_in_field;
    len_re              = 1'b0;
    len_raddr           = drain_slot;
    emit_load           = 1'b0;

    case (state)
      ngga_pkg::ST_IDLE: begin
        if (rx_fire) begin
          if (rx.rx_byte == ngga_pkg::CH_CR) begin
            // carriage return: ignored
          end else if (rx.rx_byte == ngga_pkg::CH_LF) begin
            if (gga_match) begin
              kind_cnt_next = ngga_pkg::KIND_NAME;
              state_next    = ngga_pkg::ST_RD0;
            end else begin
              kind_cnt_next = ngga_pkg::KIND_NOT_GGA;
              len_reg_next  = '0;
              state_next    = ngga_pkg::ST_EMIT;
            end
          end else if (line_length < 8'(LINE_BYTES)) begin
            line_length_next = line_length + 8'd1;
            if (content_ended) begin
              // content already ended by a zero byte
            end else if (rx.rx_byte == ngga_pkg::CH_NUL) begin
              content_ended_next = 1'b1;
            end else if (rx.rx_byte == ngga_pkg::CH_COMMA) begin
              // close the field: store its length, check the name on the first one
              len_we = slot_ok;
              if (closed_count == 4'd0) begin
                text_re        = 1'b1;
                text_raddr     = '0;
                op_next        = ngga_pkg::OP_CHECK;
                pend_long_next = (chars_in_field >= 5'd6);
                state_next     = ngga_pkg::ST_WRITE;
              end
              if (closed_count != ngga_pkg::FIELD_COUNT_MAX) begin
                closed_count_next = closed_count + 4'd1;
              end
              chars_in_field_next = '0;
            end else if (chars_in_field < 5'(FIELD_CHARS)) begin
              // keep the character: fetch its word for a byte merge
              if (slot_ok) begin
                text_re        = 1'b1;
                text_raddr     = TAW'({slot, chars_in_field[3]});
                pend_addr_next = TAW'({slot, chars_in_field[3]});
                pend_lane_next = chars_in_field[2:0];
                pend_byte_next = rx.rx_byte;
                op_next        = ngga_pkg::OP_CHAR;
                state_next     = ngga_pkg::ST_WRITE;
              end
              chars_in_field_next = chars_in_field + 5'd1;
            end else begin
              chars_in_field_next = 5'(FIELD_CHARS) + 5'd1;
            end
          end
        end
      end

      ngga_pkg::ST_WRITE: begin
        state_next = ngga_pkg::ST_IDLE;
        case (op)
          ngga_pkg::OP_CHAR: begin
            text_we = 1'b1;
            for (int i = 0; i < 8; i++) begin
              text_wdata[8*i +: 8] = (3'(i) == pend_lane) ? pend_byte
                                                           : text_rdata[8*i +: 8];
            end
          end
          ngga_pkg::OP_CHECK: begin
            gga_match_next = pend_long &&
                             (text_rdata[31:24] == ngga_pkg::CH_G) &&
                             (text_rdata[39:32] == ngga_pkg::CH_G) &&
                             (text_rdata[47:40] == ngga_pkg::CH_A);
          end
          default: begin
          end
        endcase
      end

      ngga_pkg::ST_RD0: begin
        text_re    = 1'b1;
        text_raddr = TAW'({drain_slot, 1'b0});
        len_re     = 1'b1;
        state_next = ngga_pkg::ST_RD1;
      end

      ngga_pkg::ST_RD1: begin
        text_re      = 1'b1;
        text_raddr   = TAW'({drain_slot, 1'b1});
        word0_next   = text_rdata;
        len_reg_next = len_rdata;
        state_next   = ngga_pkg::ST_EMIT;
      end

      ngga_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_load = 1'b1;
          if (emit_last) begin
            line_length_next    = '0;
            closed_count_next   = '0;
            chars_in_field_next = '0;
            content_ended_next  = 1'b0;
            gga_match_next      = 1'b0;
            state_next          = ngga_pkg::ST_IDLE;
          end else begin
            kind_cnt_next = kind_cnt + 4'd1;
            state_next    = ngga_pkg::ST_RD0;
          end
        end
      end

      default: begin
        state_next = ngga_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ngga_pkg::ST_IDLE;
      line_length    <= '0;
      closed_count   <= '0;
      chars_in_field <= '0;
      content_ended  <= 1'b0;
      gga_match      <= 1'b0;
    end else begin
      state          <= state_next;
      line_length    <= line_length_next;
      closed_count   <= closed_count_next;
      chars_in_field <= chars_in_field_next;
      content_ended  <= content_ended_next;
      gga_match      <= gga_match_next;
    end
  end

  // Pending write-back and drain payload
  always_ff @(posedge clk) begin
    op        <= op_next;
    pend_byte <= pend_byte_next;
    pend_lane <= pend_lane_next;
    pend_addr <= pend_addr_next;
    pend_long <= pend_long_next;
    kind_cnt  <= kind_cnt_next;
    word0     <= word0_next;
    len_reg   <= len_reg_next;
  end

  // Field text: two words per kept field
  ngga_ram #(
    .WIDTH (WW),
    .DEPTH (ngga_pkg::TEXT_WORDS)
  ) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (text_waddr),
    .wdata (text_wdata),
    .re    (text_re),
    .raddr (text_raddr),
    .rdata (text_rdata)
  );

  // Field lengths: one entry per kept field
  ngga_ram #(
    .WIDTH (LW),
    .DEPTH (ngga_pkg::STORED)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  ngga_out_stage #(
    .FIELD_CHARS (FIELD_CHARS)
  ) u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .load   (emit_load),
    .raw    (raw),
    .free   (out_free),
    .result (result)
  );

  // Checks
  `NGGA_ASSERT_NXT(a_line_cleared, clk, rst, emit_load && emit_last, closed_count == 4'd0 && !gga_match && line_length == 8'd0)
  `NGGA_ASSERT_IMP(a_write_after_idle, clk, rst, state == ngga_pkg::ST_WRITE, $past(state) == ngga_pkg::ST_IDLE)
  `NGGA_ASSERT_IMP(a_chars_bound, clk, rst, 1'b1, chars_in_field <= 5'(FIELD_CHARS) + 5'd1)
  `NGGA_ASSERT_IMP(a_fields_need_match, clk, rst, emit_load && kind_cnt != ngga_pkg::KIND_NOT_GGA, gga_match)

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the NMEA GGA field extractor: directed lines, then random lines.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_BYTES  = 150;
  localparam int FIELD_CHARS = 16;
  localparam int RAND_LINES  = 3;
  localparam int CALM_ROWS   = 5;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 64;
  localparam int CYCLE_LIMIT = 400000;

  // One result transaction, laid out as on the result channel
  typedef struct packed {
    logic [ngga_pkg::KIND_W-1:0] kind;
    logic [ngga_pkg::WORD_W-1:0] text_low;
    logic [ngga_pkg::WORD_W-1:0] text_high;
    logic [ngga_pkg::LEN_W-1:0]  text_length;
    logic                        truncated;
    logic                        last;
  } gga_field_t;

  // Directed line: head, then pad_n copies of pad_c, then tail
  typedef struct {
    string      head;
    int         pad_n;
    logic [7:0] pad_c;
    string      tail;
    bit         typed;
    gga_field_t want;
  } dir_row_t;

  // Ways a random GGA line is damaged
  typedef enum int {
    DEF_NONE,
    DEF_NAME,
    DEF_NUL,
    DEF_LONG,
    DEF_SHORT
  } line_defect_t;

  logic clk = 1'b0;
  logic rst;

  ngga_byte_if   rx_ch ();
  ngga_result_if res_ch ();

  nmea_gga_field_extractor #(
    .LINE_BYTES  (LINE_BYTES),
    .FIELD_CHARS (FIELD_CHARS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch)
  );

  always #6 clk = ~clk;

  // Line parser state mirrored by the testbench
  logic [7:0]                  ln_count;
  logic [3:0]                  closed_cnt;
  logic [ngga_pkg::LEN_W-1:0]  open_chars;
  bit                          nul_seen;
  bit                          gga_hit;
  logic [ngga_pkg::WORD_W-1:0] fld_text [ngga_pkg::TEXT_WORDS];
  logic [ngga_pkg::LEN_W-1:0]  fld_len [ngga_pkg::STORED];

  gga_field_t expected_fields [$];
  gga_field_t new_fields [$];
  logic [7:0] line_buf [$];
  dir_row_t   dir_rows [$];

  bit         typed_on;
  gga_field_t typed_want;
  bit         calm;
  bit         hold_pending;
  int         errors;
  int         bytes_sent;
  int         cycles;

  function automatic gga_field_t mk_field(input logic [ngga_pkg::KIND_W-1:0] kind,
                                          input logic [ngga_pkg::WORD_W-1:0] lo,
                                          input logic [ngga_pkg::WORD_W-1:0] hi,
                                          input logic [ngga_pkg::LEN_W-1:0] len,
                                          input logic tr, input logic lst);
    return {kind, lo, hi, len, tr, lst};
  endfunction

  function automatic logic [ngga_pkg::WORD_W-1:0] keep_mask(input int n);
    if (n >= 8) return '1;
    return (64'h1 << (8 * n)) - 64'h1;
  endfunction

  // Storage slot of a field; HDOP (ninth field) and fields past eleven are not kept
  function automatic int field_slot(input logic [3:0] f);
    if (f < 4'd8) return int'(f);
    if (f == 4'd9 || f == 4'd10) return int'(f) - 1;
    return -1;
  endfunction

  function automatic void restart_line();
    ln_count   = '0;
    closed_cnt = '0;
    open_chars = '0;
    nul_seen   = 1'b0;
    gga_hit    = 1'b0;
  endfunction

  // Track one accepted byte; a newline leaves its result transactions in new_fields
  function automatic void extract_fields(input logic [7:0] b);
    int                         k;
    int                         f;
    int                         s;
    int                         carried;
    bit                         single;
    logic [ngga_pkg::LEN_W-1:0] len;
    gga_field_t                 r;
    new_fields.delete();
    if (b == ngga_pkg::CH_CR) return;
    if (b == ngga_pkg::CH_LF) begin
      if (gga_hit) begin
        for (k = 1; k <= 10; k++) begin
          f = (k <= 8) ? k - 1 : k;
          if (f >= int'(closed_cnt)) break;
          len = fld_len[k-1];
          single = (k == int'(ngga_pkg::KIND_NS)) || (k == int'(ngga_pkg::KIND_EW)) ||
                   (k == int'(ngga_pkg::KIND_QUALITY)) ||
                   (k == int'(ngga_pkg::KIND_SATS)) || (k == int'(ngga_pkg::KIND_UNIT));
          if (single) begin
            carried = (len > 0) ? 1 : 0;
            r.truncated = (len > 1);
          end else begin
            carried = (len > FIELD_CHARS) ? FIELD_CHARS : int'(len);
            r.truncated = (len > FIELD_CHARS);
          end
          r.kind        = ngga_pkg::KIND_W'(k);
          r.text_low    = fld_text[2*(k-1)] & keep_mask(carried);
          r.text_high   = (carried > 8) ? (fld_text[2*(k-1)+1] & keep_mask(carried - 8)) : '0;
          r.text_length = ngga_pkg::LEN_W'(carried);
          r.last        = 1'b0;
          new_fields.push_back(r);
        end
      end
      if (new_fields.size() == 0)
        new_fields.push_back(mk_field(ngga_pkg::KIND_NOT_GGA, '0, '0, '0, 1'b0, 1'b0));
      new_fields[new_fields.size()-1].last = 1'b1;
      restart_line();
      return;
    end
    // Line limit, then zero byte ending the content
    if (ln_count >= LINE_BYTES) return;
    ln_count++;
    if (nul_seen) return;
    if (b == ngga_pkg::CH_NUL) begin
      nul_seen = 1'b1;
      return;
    end
    s = field_slot(closed_cnt);
    if (b == ngga_pkg::CH_COMMA) begin
      if (s >= 0) fld_len[s] = open_chars;
      if (closed_cnt == 0)
        gga_hit = (open_chars >= 6) && (fld_text[0][31:24] == ngga_pkg::CH_G) &&
                  (fld_text[0][39:32] == ngga_pkg::CH_G) &&
                  (fld_text[0][47:40] == ngga_pkg::CH_A);
      if (closed_cnt < ngga_pkg::FIELD_COUNT_MAX) closed_cnt++;
      open_chars = '0;
      return;
    end
    // Ordinary character, kept up to FIELD_CHARS
    if (open_chars < FIELD_CHARS) begin
      if (s >= 0) fld_text[2*s + open_chars[3]][8*open_chars[2:0] +: 8] = b;
      open_chars++;
    end else begin
      open_chars = ngga_pkg::LEN_W'(FIELD_CHARS + 1);
    end
  endfunction

  // Gap length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [ngga_pkg::WORD_W-1:0] got,
                                 input logic [ngga_pkg::WORD_W-1:0] want);
    errors++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // Offer one byte, wait for its transaction, then predict
  task automatic send_byte(input logic [7:0] b);
    int gap;
    int i;
    gap = idle_len();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    extract_fields(b);
    bytes_sent++;
    if (typed_on && new_fields.size() > 0) begin
      expected_fields.push_back(typed_want);
    end else begin
      for (i = 0; i < new_fields.size(); i++) expected_fields.push_back(new_fields[i]);
    end
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  function automatic void add_row(input string head, input int pad_n, input logic [7:0] pad_c,
                                  input string tail, input bit typed, input gga_field_t want);
    dir_row_t row;
    row.head  = head;
    row.pad_n = pad_n;
    row.pad_c = pad_c;
    row.tail  = tail;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // In directed text '^' stands for a zero byte and '~' for 8'hFF
  function automatic logic [7:0] map_char(input logic [7:0] c);
    if (c == "^") return ngga_pkg::CH_NUL;
    if (c == "~") return 8'hFF;
    return c;
  endfunction

  function automatic int field_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 5);
    if (r < 95) return $urandom_range(6, 16);
    return $urandom_range(17, 24);
  endfunction

  function automatic logic [7:0] field_char();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(48, 57));
    if (r < 70) return ".";
    if (r < 88) begin
      c = 8'($urandom_range(32, 126));
      return (c == ngga_pkg::CH_COMMA) ? 8'(".") : c;
    end
    if (r < 97) return 8'($urandom_range(128, 255));
    return ngga_pkg::CH_CR;
  endfunction

  // Build a GGA sentence with random content, optionally damaged; full gives every kept field
  function automatic void build_gga(input line_defect_t defect, input bit full);
    int nf;
    int keep;
    int i;
    int pos;
    line_buf.delete();
    line_buf.push_back("$");
    line_buf.push_back(8'($urandom_range(65, 90)));
    line_buf.push_back(8'($urandom_range(65, 90)));
    line_buf.push_back(ngga_pkg::CH_G);
    line_buf.push_back(ngga_pkg::CH_G);
    line_buf.push_back(ngga_pkg::CH_A);
    if ($urandom_range(0, 9) == 0) line_buf.push_back(8'($urandom_range(65, 90)));
    if (defect == DEF_NAME) line_buf[3 + $urandom_range(0, 2)] = 8'($urandom_range(65, 90));
    if (defect == DEF_SHORT) begin
      keep = $urandom_range(1, 5);
      while (line_buf.size() > keep) void'(line_buf.pop_back());
    end
    line_buf.push_back(ngga_pkg::CH_COMMA);
    nf = (full || $urandom_range(0, 99) < 65) ? $urandom_range(10, 12) : $urandom_range(0, 14);
    for (i = 0; i < nf; i++) begin
      repeat (field_len()) line_buf.push_back(field_char());
      line_buf.push_back(ngga_pkg::CH_COMMA);
    end
    repeat ($urandom_range(0, 3)) line_buf.push_back(field_char());
    if (defect == DEF_LONG) repeat ($urandom_range(150, 170)) line_buf.push_back(field_char());
    if (defect == DEF_NUL) begin
      pos = $urandom_range(1, line_buf.size());
      line_buf.insert(pos, ngga_pkg::CH_NUL);
    end
    if ($urandom_range(0, 1) == 1) line_buf.push_back(ngga_pkg::CH_CR);
    line_buf.push_back(ngga_pkg::CH_LF);
  endfunction

  function automatic void build_noise();
    line_buf.delete();
    repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
    line_buf.push_back(ngga_pkg::CH_LF);
  endfunction

  // Result receiver: random stalls, one long hold-off on request, calm stretches
  initial begin : result_ready_gen
    int n;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm) begin
        res_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        n = idle_len();
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    gga_field_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_fields.size() == 0) begin
        report_mismatch("unexpected result, kind", 64'(res_ch.kind), '0);
      end else begin
        want = expected_fields.pop_front();
        if (res_ch.kind !== want.kind)
          report_mismatch("kind", 64'(res_ch.kind), 64'(want.kind));
        if (res_ch.text_low !== want.text_low)
          report_mismatch("text_low", res_ch.text_low, want.text_low);
        if (res_ch.text_high !== want.text_high)
          report_mismatch("text_high", res_ch.text_high, want.text_high);
        if (res_ch.text_length !== want.text_length)
          report_mismatch("text_length", 64'(res_ch.text_length), 64'(want.text_length));
        if (res_ch.truncated !== want.truncated)
          report_mismatch("truncated", 64'(res_ch.truncated), 64'(want.truncated));
        if (res_ch.last !== want.last)
          report_mismatch("last", 64'(res_ch.last), 64'(want.last));
      end
    end
  end

  // Watchdog
  initial begin : cycle_watch
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    gga_field_t not_gga;
    int         i;
    int         j;
    int         r;
    int         line_no;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    errors       = 0;
    bytes_sent   = 0;
    typed_on     = 1'b0;
    calm         = 1'b0;
    hold_pending = 1'b0;
    restart_line();
    for (i = 0; i < ngga_pkg::TEXT_WORDS; i++) fld_text[i] = '0;
    for (i = 0; i < ngga_pkg::STORED; i++) fld_len[i] = '0;

    not_gga = mk_field(ngga_pkg::KIND_NOT_GGA, '0, '0, '0, 1'b0, 1'b1);
    add_row("\n", 0, 0, "", 1'b1, not_gga);
    add_row("$GPRMC,1,2\015\n", 0, 0, "", 1'b1, not_gga);
    add_row("$GPGGA\n", 0, 0, "", 1'b1, not_gga);
    add_row("$GGA,\n", 0, 0, "", 1'b1, not_gga);
    add_row("$GPGGA,\n", 0, 0, "", 1'b1,
            mk_field(ngga_pkg::KIND_NAME, 64'h0000_4147_4750_4724, '0, 5'd6, 1'b0, 1'b1));
    add_row("$GPGGA,0123456789ABCDEFGH,NS,\n", 0, 0, "", 1'b0, not_gga);
    add_row("$GPGGA,1^,2,3,\n", 0, 0, "", 1'b0, not_gga);
    add_row("$GPGGA,~~,\n", 0, 0, "", 1'b0, not_gga);
    add_row("$GPGGA,1,2,NN,3,EW,12,08,x,4,MM,\n", 0, 0, "", 1'b0, not_gga);
    add_row("$GPGGA,", 20, ngga_pkg::CH_COMMA, "\n", 1'b0, not_gga);
    // Line limit: the closing comma lands past the first LINE_BYTES bytes
    add_row("$GPGGA,1,", 143, "x", ",\n", 1'b0, not_gga);
    add_row("\015\015\n", 0, 0, "", 1'b1, not_gga);
    add_row("$XXGGA12,\015,\n", 0, 0, "", 1'b0, not_gga);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed lines; the first few run with no gaps and an always-ready receiver
    for (i = 0; i < dir_rows.size(); i++) begin
      for (j = 0; j < dir_rows[i].head.len(); j++)
        line_buf.push_back(map_char(dir_rows[i].head[j]));
      repeat (dir_rows[i].pad_n) line_buf.push_back(dir_rows[i].pad_c);
      for (j = 0; j < dir_rows[i].tail.len(); j++)
        line_buf.push_back(map_char(dir_rows[i].tail[j]));
      calm       = (i < CALM_ROWS);
      typed_on   = dir_rows[i].typed;
      typed_want = dir_rows[i].want;
      send_line();
    end
    typed_on = 1'b0;
    calm     = 1'b0;

    // Random lines: a full GGA line first, then the receiver holds off while more are offered
    for (line_no = 0; line_no < RAND_LINES; line_no++) begin
      r = $urandom_range(0, 99);
      if (line_no == 0) begin
        build_gga(DEF_NONE, 1'b1);
      end else if (r < 70) begin
        build_gga(DEF_NONE, 1'b0);
      end else if (r < 85) begin
        build_noise();
      end else begin
        build_gga(line_defect_t'($urandom_range(int'(DEF_NAME), int'(DEF_SHORT))), 1'b0);
      end
      if (line_no == 1) hold_pending = 1'b1;
      send_line();
    end
    rx_ch.valid <= 1'b0;

    while (expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ngga_pkg.sv
src/ngga_if.sv
src/ngga_ram.sv
src/ngga_out_stage.sv
src/nmea_gga_field_extractor.sv
test/tb_top.sv
